FILE: hdl/tts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick task scheduler package
// Shared widths, codes and control structs for the slot table scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  // Table size and the widths that follow from it.
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // Fixed field widths of the channel words.
  localparam int TAG_W  = 8;
  localparam int TYPE_W = 2;
  localparam int IVL_W  = 32;
  localparam int IDX_W  = 3;
  localparam int RK_W   = 2;

  // Input item kinds.
  localparam logic KIND_ATTACH = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Task types held in the slot table.
  localparam logic [TYPE_W-1:0] TT_ONESHOT  = 2'd0;
  localparam logic [TYPE_W-1:0] TT_ALWAYS   = 2'd1;
  localparam logic [TYPE_W-1:0] TT_PERIODIC = 2'd2;

  // Result word kinds.
  typedef enum logic [RK_W-1:0] {
    RK_ATTACH = 2'd0,
    RK_FIRED  = 2'd1,
    RK_EMPTY  = 2'd2
  } rkind_t;

  // One input word.
  typedef struct packed {
    logic              kind;
    logic [TAG_W-1:0]  task_tag;
    logic [TYPE_W-1:0] task_type;
    logic              start_active;
    logic [IVL_W-1:0]  tick_interval;
  } in_item_t;

  // One result word.
  typedef struct packed {
    rkind_t           result_kind;
    logic             attach_error;
    logic [IDX_W-1:0] slot_index;
    logic [TAG_W-1:0] fired_tag;
    logic             last;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic attach;
    logic scan_start;
    logic step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;
    logic fires;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/tts_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler input channel
// Valid/ready channel that carries attach and tick words.
// ----------------------------------------------------------------------------
interface tts_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [tts_pkg::TAG_W-1:0]   task_tag;
  logic [tts_pkg::TYPE_W-1:0]  task_type;
  logic                        start_active;
  logic [tts_pkg::IVL_W-1:0]   tick_interval;

  modport source (
    output valid, kind, task_tag, task_type, start_active, tick_interval,
    input  ready
  );

  modport sink (
    input  valid, kind, task_tag, task_type, start_active, tick_interval,
    output ready
  );
endinterface

FILE: hdl/tts_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel that carries attach status, firing and marker words.
// ----------------------------------------------------------------------------
interface tts_out_if;
  logic                       valid;
  logic                       ready;
  logic [tts_pkg::RK_W-1:0]   result_kind;
  logic                       attach_error;
  logic [tts_pkg::IDX_W-1:0]  slot_index;
  logic [tts_pkg::TAG_W-1:0]  fired_tag;
  logic                       last;

  modport source (
    output valid, result_kind, attach_error, slot_index, fired_tag, last,
    input  ready
  );

  modport sink (
    input  valid, result_kind, attach_error, slot_index, fired_tag, last,
    output ready
  );
endinterface

FILE: hdl/tts_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler datapath
// Slot table, scan pointer, pending firing word and result output register.
// ----------------------------------------------------------------------------
module tts_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  tts_pkg::cmd_t     cmd,
  input  tts_pkg::in_item_t in_item,
  output tts_pkg::sts_t     sts,
  output logic              out_valid,
  input  logic              out_ready,
  output tts_pkg::res_t     out_res
);
  import tts_pkg::*;

  // Slot table, written by attach and by the tick scan.
  logic [TAG_W-1:0]  tag_mem [SLOT_COUNT];
  logic [TYPE_W-1:0] type_mem [SLOT_COUNT];
  logic              act_mem [SLOT_COUNT];
  logic [IVL_W-1:0]  lim_mem [SLOT_COUNT];
  logic [IVL_W-1:0]  ctr_mem [SLOT_COUNT];

  logic [CNT_W-1:0] filled_r;
  logic [CNT_W-1:0] idx_r;
  logic             pend_valid_r;
  res_t             pend_r;
  logic             out_valid_r;
  res_t             out_r;

  logic [SLOT_IW-1:0] slot_sel;
  logic [SLOT_IW-1:0] wr_sel;
  logic               table_full;
  logic [TAG_W-1:0]   cur_tag;
  logic [TYPE_W-1:0]  cur_type;
  logic               cur_act;
  logic [IVL_W-1:0]   cur_lim;
  logic [IVL_W-1:0]   cur_ctr;
  logic [IVL_W-1:0]   ctr_inc;
  logic [IVL_W-1:0]   ctr_wrap;
  logic               fires;
  logic               out_free;
  logic               push_mid;
  logic               load_out;

  // Current slot under the scan pointer and the attach target.
  assign slot_sel   = idx_r[SLOT_IW-1:0];
  assign wr_sel     = filled_r[SLOT_IW-1:0];
  assign table_full = (filled_r == CNT_W'(SLOT_COUNT));
  assign cur_tag    = tag_mem[slot_sel];
  assign cur_type   = type_mem[slot_sel];
  assign cur_act    = act_mem[slot_sel];
  assign cur_lim    = lim_mem[slot_sel];
  assign cur_ctr    = ctr_mem[slot_sel];

  // A slot fires when active with its counter at zero.
  assign fires    = cur_act && (cur_ctr == '0);
  assign ctr_inc  = cur_ctr + IVL_W'(1);
  assign ctr_wrap = (ctr_inc > cur_lim) ? '0 : ctr_inc;

  // A new firing pushes the held one out as a middle word.
  assign out_free = !out_valid_r || out_ready;
  assign push_mid = cmd.step && fires && pend_valid_r;
  assign load_out = push_mid || cmd.finish;

  always_comb begin
    sts.scan_end   = (idx_r == filled_r);
    sts.fires      = fires;
    sts.pend_valid = pend_valid_r;
    sts.out_free   = out_free;
  end

  // Slot table writes.
  always_ff @(posedge clk) begin
    if (cmd.attach && !table_full) begin
      tag_mem[wr_sel]  <= in_item.task_tag;
      type_mem[wr_sel] <= in_item.task_type;
      act_mem[wr_sel]  <= in_item.start_active;
      lim_mem[wr_sel]  <= in_item.tick_interval;
      ctr_mem[wr_sel]  <= '0;
    end else if (cmd.step && cur_act) begin
      case (cur_type)
        TT_ONESHOT: begin
          act_mem[slot_sel] <= 1'b0;
          ctr_mem[slot_sel] <= '0;
        end
        TT_ALWAYS: begin
          ctr_mem[slot_sel] <= '0;
        end
        TT_PERIODIC: begin
          ctr_mem[slot_sel] <= ctr_wrap;
        end
        default: begin
        end
      endcase
    end
  end

  // Fill count, scan pointer and valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r     <= '0;
      idx_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.attach && !table_full) begin
        filled_r <= filled_r + CNT_W'(1);
      end
      if (cmd.scan_start) begin
        idx_r <= '0;
      end else if (cmd.step) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cmd.attach) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.scan_start || cmd.finish) begin
        pend_valid_r <= 1'b0;
      end else if (cmd.step && fires) begin
        pend_valid_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pending word and output word payload.
  always_ff @(posedge clk) begin
    if (cmd.attach) begin
      pend_r.result_kind  <= RK_ATTACH;
      pend_r.attach_error <= table_full;
      pend_r.slot_index   <= table_full ? '0 : IDX_W'(filled_r);
      pend_r.fired_tag    <= '0;
      pend_r.last         <= 1'b1;
    end else if (cmd.step && fires) begin
      pend_r.result_kind  <= RK_FIRED;
      pend_r.attach_error <= 1'b0;
      pend_r.slot_index   <= IDX_W'(slot_sel);
      pend_r.fired_tag    <= cur_tag;
      pend_r.last         <= 1'b0;
    end
    if (push_mid) begin
      out_r      <= pend_r;
      out_r.last <= 1'b0;
    end else if (cmd.finish) begin
      if (pend_valid_r) begin
        out_r      <= pend_r;
        out_r.last <= 1'b1;
      end else begin
        out_r.result_kind  <= RK_EMPTY;
        out_r.attach_error <= 1'b0;
        out_r.slot_index   <= '0;
        out_r.fired_tag    <= '0;
        out_r.last         <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

FILE: hdl/tts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences attach and tick words over the datapath, one slot per cycle while the scan is not held.
// ----------------------------------------------------------------------------
module tts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_kind,
  output logic          in_ready,
  input  tts_pkg::sts_t sts,
  output tts_pkg::cmd_t cmd
);
  import tts_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;
  logic   in_ready_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          if (in_kind == KIND_TICK) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            cmd.attach = 1'b1;
            state_nxt  = ST_FINAL;
          end
        end
      end
      ST_SCAN: begin
        // Hold the scan when a second firing would need a full output register.
        if (sts.scan_end) begin
          state_nxt = ST_FINAL;
        end else if (!(sts.fires && sts.pend_valid && !sts.out_free)) begin
          cmd.step = 1'b1;
        end
      end
      ST_FINAL: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    in_ready_nxt = (state_nxt == ST_IDLE);
  end

  // State and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

FILE: hdl/tick_task_slot_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick task slot scheduler
// Slot table scheduler that attaches tasks and reports firings on each tick.
// ----------------------------------------------------------------------------
// Usage:
// The in_chan channel takes one word at a time: an attach word fills the next
// free slot, a tick word walks the filled slots from slot zero upward. The
// out_chan channel returns one status word per attach, one word per task that
// fires on a tick, or one marker word for a tick on which nothing fires. The
// final word of each input carries last.
// An attach status word passes through the pending register into the output
// register. A tick's final word is loaded into the output register once the
// scan has walked all filled slots; the scan reads the slot table at one slot
// per cycle while it is not held. The block takes no new word while it works
// on one: a new word can be accepted in the cycle after the final word of the
// previous one is loaded into the output register.
// Reset clears the fill count, so the table is empty; slot contents are not
// cleared and no clearing pass is needed. When the receiver stalls, the output
// register holds its word and one further firing waits in a pending register;
// the scan then pauses on the next firing slot until the output register frees.
// ----------------------------------------------------------------------------
module tick_task_slot_scheduler_core (
  input  logic     clk,
  input  logic     rst_n,
  tts_in_if.sink   in_chan,
  tts_out_if.source out_chan
);
  import tts_pkg::*;

  in_item_t in_item;
  res_t     out_res;
  cmd_t     cmd;
  sts_t     sts;
  logic     in_ready;
  logic     out_valid;

  always_comb begin
    in_item.kind          = in_chan.kind;
    in_item.task_tag      = in_chan.task_tag;
    in_item.task_type     = in_chan.task_type;
    in_item.start_active  = in_chan.start_active;
    in_item.tick_interval = in_chan.tick_interval;
  end

  tts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_kind  (in_chan.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tts_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  // Channel outputs.
  assign in_chan.ready         = in_ready;
  assign out_chan.valid        = out_valid;
  assign out_chan.result_kind  = out_res.result_kind;
  assign out_chan.attach_error = out_res.attach_error;
  assign out_chan.slot_index   = out_res.slot_index;
  assign out_chan.fired_tag    = out_res.fired_tag;
  assign out_chan.last         = out_res.last;

  // One word at a time: the block is busy right after it accepts a word.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input accepted while a previous word is still in work");

  // Attach status words are always final and carry no tag.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.result_kind == RK_ATTACH)) |->
      (out_chan.last && (out_chan.fired_tag == '0)))
    else $error("attach status word is malformed");

  // Tick marker words are final and carry zero error, slot and tag fields.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.result_kind == RK_EMPTY)) |->
      (out_chan.last && !out_chan.attach_error && (out_chan.slot_index == '0)
       && (out_chan.fired_tag == '0)))
    else $error("tick marker word is malformed");

  // Firing words never flag an attach error.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.result_kind == RK_FIRED)) |-> !out_chan.attach_error)
    else $error("firing word carries an attach error");

endmodule
